// ===== rtl/core/lz77_token_decompressor_top_macros.svh =====
// Assertion macros shared by the decompressor RTL.
`ifndef LZ77_TOKEN_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ77_TOKEN_DECOMPRESSOR_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LZD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define LZD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lzd_pkg.sv =====
// Shared types, codes and default parameters of the LZ77 token decompressor.
`timescale 1ns / 1ps

package lzd_pkg;

  localparam int DEF_HISTORY_DEPTH = 4096;
  localparam int DEF_OFFSET_BYTES  = 2;
  localparam int DEF_LENGTH_BYTES  = 1;
  localparam int DEF_MAX_COPY      = 63;

  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t STS_DATA       = 2'd0;
  localparam status_t STS_BAD_OFFSET = 2'd1;
  localparam status_t STS_BAD_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_LIT  = 2'd1,
    CMD_COPY = 2'd2,
    CMD_ERR  = 2'd3
  } cmd_kind_t;

  // Command from the token parser for one accepted byte.
  typedef struct packed {
    cmd_kind_t kind;
    status_t   status;
  } cmd_t;

endpackage

// ===== rtl/core/lzd_hist_ram.sv =====
// History window RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lzd_hist_ram #(
  parameter int DEPTH = lzd_pkg::DEF_HISTORY_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lzd_parser.sv =====
// Token parser: gathers offset and length fields, checks them, issues commands.
`timescale 1ns / 1ps

module lzd_parser #(
  parameter int HISTORY_DEPTH = lzd_pkg::DEF_HISTORY_DEPTH,
  parameter int OFFSET_BYTES  = lzd_pkg::DEF_OFFSET_BYTES,
  parameter int LENGTH_BYTES  = lzd_pkg::DEF_LENGTH_BYTES,
  parameter int MAX_COPY      = lzd_pkg::DEF_MAX_COPY,
  parameter int PW            = $clog2(HISTORY_DEPTH) + 1,
  parameter int CW            = $clog2(MAX_COPY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    in_byte,
  input  logic          stream_start,
  input  logic          msb_first,
  input  logic [PW-1:0] produced,
  output lzd_pkg::cmd_t cmd,
  output logic [CW-1:0] cmd_len,
  output logic [PW-1:0] cmd_off
);

  localparam int OFW   = 8 * OFFSET_BYTES;
  localparam int LNW   = 8 * LENGTH_BYTES;
  localparam int MAXB  = (OFFSET_BYTES > LENGTH_BYTES) ? OFFSET_BYTES : LENGTH_BYTES;
  localparam int IW    = $clog2(MAXB + 1);
  localparam int CMPW  = (OFW > PW) ? OFW : PW;

  typedef enum logic [3:0] {
    PH_OFFSET  = 4'b0001,
    PH_LENGTH  = 4'b0010,
    PH_LITERAL = 4'b0100,
    PH_NEXT    = 4'b1000
  } phase_t;

  phase_t          phase_r, phase_nxt, cur_phase;
  logic [IW-1:0]   idx_r, idx_nxt, cur_idx;
  logic [OFW-1:0]  off_r, off_nxt, cur_off, off_acc;
  logic [LNW-1:0]  len_r, len_nxt, cur_len, len_acc;
  logic [LNW-1:0]  lit_r, lit_nxt, cur_lit;
  logic            err_r, err_nxt, cur_err;
  logic [PW-1:0]   eff_prod;
  logic            off_over;
  lzd_pkg::cmd_t   cmd_c;

  // A stream start clears the parser before its byte is handled.
  assign cur_phase = stream_start ? PH_OFFSET : phase_r;
  assign cur_idx   = stream_start ? '0 : idx_r;
  assign cur_off   = stream_start ? '0 : off_r;
  assign cur_len   = stream_start ? '0 : len_r;
  assign cur_lit   = stream_start ? '0 : lit_r;
  assign cur_err   = stream_start ? 1'b0 : err_r;
  assign eff_prod  = stream_start ? '0 : produced;

  assign off_acc = msb_first ? ((cur_off << 8) | OFW'(in_byte))
                             : (cur_off | (OFW'(in_byte) << {cur_idx, 3'b000}));
  assign len_acc = msb_first ? ((cur_len << 8) | LNW'(in_byte))
                             : (cur_len | (LNW'(in_byte) << {cur_idx, 3'b000}));

  assign off_over = (off_acc != '0) && (CMPW'(off_acc) > CMPW'(eff_prod));

  always_comb begin
    phase_nxt   = cur_phase;
    idx_nxt     = cur_idx;
    off_nxt     = cur_off;
    len_nxt     = cur_len;
    lit_nxt     = cur_lit;
    err_nxt     = cur_err;
    cmd_c.kind   = lzd_pkg::CMD_NONE;
    cmd_c.status = lzd_pkg::STS_DATA;
    if (!cur_err) begin
      unique case (cur_phase)
        PH_OFFSET: begin
          if (cur_idx == IW'(OFFSET_BYTES - 1)) begin
            idx_nxt = '0;
            if (off_over) begin
              err_nxt      = 1'b1;
              off_nxt      = '0;
              len_nxt      = '0;
              cmd_c.kind   = lzd_pkg::CMD_ERR;
              cmd_c.status = lzd_pkg::STS_BAD_OFFSET;
            end else begin
              off_nxt   = off_acc;
              phase_nxt = PH_LENGTH;
            end
          end else begin
            idx_nxt = cur_idx + 1'b1;
            off_nxt = off_acc;
          end
        end
        PH_LENGTH: begin
          if (cur_idx == IW'(LENGTH_BYTES - 1)) begin
            idx_nxt = '0;
            if (cur_off == '0) begin
              if (len_acc == '0) begin
                phase_nxt = PH_OFFSET;
                len_nxt   = '0;
              end else begin
                lit_nxt   = len_acc;
                len_nxt   = len_acc;
                phase_nxt = PH_LITERAL;
              end
            end else if (len_acc > LNW'(MAX_COPY)) begin
              err_nxt      = 1'b1;
              phase_nxt    = PH_OFFSET;
              off_nxt      = '0;
              len_nxt      = '0;
              cmd_c.kind   = lzd_pkg::CMD_ERR;
              cmd_c.status = lzd_pkg::STS_BAD_LENGTH;
            end else begin
              len_nxt   = len_acc;
              phase_nxt = PH_NEXT;
            end
          end else begin
            idx_nxt = cur_idx + 1'b1;
            len_nxt = len_acc;
          end
        end
        PH_LITERAL: begin
          cmd_c.kind = lzd_pkg::CMD_LIT;
          lit_nxt    = cur_lit - 1'b1;
          if (cur_lit == LNW'(1)) begin
            phase_nxt = PH_OFFSET;
            off_nxt   = '0;
            len_nxt   = '0;
          end
        end
        PH_NEXT: begin
          // Empty copy only passes the next byte through.
          cmd_c.kind = (cur_len == '0) ? lzd_pkg::CMD_LIT : lzd_pkg::CMD_COPY;
          phase_nxt  = PH_OFFSET;
          off_nxt    = '0;
          len_nxt    = '0;
          lit_nxt    = '0;
        end
        default: begin
          phase_nxt = PH_OFFSET;
          idx_nxt   = '0;
          off_nxt   = '0;
          len_nxt   = '0;
          lit_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFFSET;
      idx_r   <= '0;
      off_r   <= '0;
      len_r   <= '0;
      lit_r   <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      off_r   <= off_nxt;
      len_r   <= len_nxt;
      lit_r   <= lit_nxt;
      err_r   <= err_nxt;
    end
  end

  assign cmd     = cmd_c;
  assign cmd_len = CW'(cur_len);
  assign cmd_off = PW'(cur_off);

endmodule

// ===== rtl/core/lz77_token_decompressor_top.sv =====
// Top level of the LZ77 token decompressor: copy sequencer, history RAM, output register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall): one compressed byte per transaction, with
//   in_stream_start marking the first byte of a new stream. Output channel
//   (out_valid / out_stall): one decompressed byte or error status per transaction;
//   out_last_of_run marks the final result caused by one input byte.
//   cfg_we / cfg_wdata set msb_first (field byte order); write only while idle.
// Sequencing:
//   Header and literal bytes are taken while the output slot is free; a literal
//   appears on the output in the cycle after its transaction. A copy token's
//   trailing byte, when length is nonzero, starts the first history read, then the
//   block replays one byte per cycle while the output slot is free (the single RAM
//   read port has registered read data; the last written byte is forwarded when a
//   read hits it), then emits the trailing byte. An empty copy passes its trailing
//   byte through like a literal. Input is held off with in_stall during the replay.
// Reset (rst_n, synchronous): parser, write pointer, counts, error hold and output valid
//   flag clear; history contents are left as they are and need no clearing
//   pass, since the offset check never lets a read reach an unwritten entry.
// Back pressure: a result waits in the output register while out_stall is high;
//   the block then accepts no input and the replay pauses without losing data.

`include "lz77_token_decompressor_top_macros.svh"

module lz77_token_decompressor_top #(
  parameter int HISTORY_DEPTH = lzd_pkg::DEF_HISTORY_DEPTH,
  parameter int OFFSET_BYTES  = lzd_pkg::DEF_OFFSET_BYTES,
  parameter int LENGTH_BYTES  = lzd_pkg::DEF_LENGTH_BYTES,
  parameter int MAX_COPY      = lzd_pkg::DEF_MAX_COPY
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  input  logic                         in_stream_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic [lzd_pkg::STATUS_W-1:0] out_status,
  output logic                         out_last_of_run,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(MAX_COPY + 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COPY = 3'b010,
    ST_TAIL = 3'b100
  } seq_state_t;

  seq_state_t       st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]       next_byte_r, next_byte_nxt;
  logic [AW-1:0]    wp_r, wp_inc;
  logic [PW-1:0]    prod_r;
  logic [AW-1:0]    rd_addr_r, raddr_inc;
  logic             fwd_r;
  logic [7:0]       fwd_byte_r;
  logic             msb_first_r;

  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  lzd_pkg::status_t out_status_r;
  logic             out_last_r;

  logic             out_free, in_fire;
  lzd_pkg::cmd_t    cmd;
  logic [CW-1:0]    cmd_len;
  logic [PW-1:0]    cmd_off;
  logic [PW-1:0]    wp_ext, src_ext;
  logic [AW-1:0]    copy_src;
  logic [7:0]       copy_byte;

  logic             out_load;
  logic [7:0]       load_byte;
  lzd_pkg::status_t load_status;
  logic             load_last;
  logic             hist_we, hist_re;
  logic [7:0]       hist_wdata, hist_rdata;
  logic [AW-1:0]    raddr;

  // Output slot is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((st_r == ST_IDLE) && out_free);
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msb_first_r <= 1'b0;
    end else if (cfg_we) begin
      msb_first_r <= cfg_wdata;
    end
  end

  lzd_parser #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .OFFSET_BYTES  (OFFSET_BYTES),
    .LENGTH_BYTES  (LENGTH_BYTES),
    .MAX_COPY      (MAX_COPY),
    .PW            (PW),
    .CW            (CW)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (in_fire),
    .in_byte      (in_byte),
    .stream_start (in_stream_start),
    .msb_first    (msb_first_r),
    .produced     (prod_r),
    .cmd          (cmd),
    .cmd_len      (cmd_len),
    .cmd_off      (cmd_off)
  );

  // Copy source: offset bytes behind the write pointer, modulo the window.
  // The parser guarantees offset <= produced <= depth.
  assign wp_ext   = {1'b0, wp_r};
  assign src_ext  = (wp_ext >= cmd_off) ? (wp_ext - cmd_off) : (wp_ext + DEPTH_P - cmd_off);
  assign copy_src = src_ext[AW-1:0];

  assign wp_inc    = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
  assign raddr_inc = (raddr == LAST_ADDR) ? '0 : raddr + 1'b1;

  // Read that hit the byte written in the same cycle takes the forwarded copy.
  assign copy_byte = fwd_r ? fwd_byte_r : hist_rdata;

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    next_byte_nxt = next_byte_r;
    out_load      = 1'b0;
    load_byte     = '0;
    load_status   = lzd_pkg::STS_DATA;
    load_last     = 1'b0;
    hist_we       = 1'b0;
    hist_wdata    = in_byte;
    hist_re       = 1'b0;
    raddr         = rd_addr_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd.kind)
            lzd_pkg::CMD_LIT: begin
              out_load   = 1'b1;
              load_byte  = in_byte;
              load_last  = 1'b1;
              hist_we    = 1'b1;
              hist_wdata = in_byte;
            end
            lzd_pkg::CMD_ERR: begin
              out_load    = 1'b1;
              load_status = cmd.status;
              load_last   = 1'b1;
            end
            lzd_pkg::CMD_COPY: begin
              hist_re       = 1'b1;
              raddr         = copy_src;
              cnt_nxt       = cmd_len;
              next_byte_nxt = in_byte;
              st_nxt        = ST_COPY;
            end
            default: begin
            end
          endcase
        end
      end
      ST_COPY: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_byte  = copy_byte;
          hist_we    = 1'b1;
          hist_wdata = copy_byte;
          cnt_nxt    = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            st_nxt = ST_TAIL;
          end else begin
            hist_re = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_byte  = next_byte_r;
          load_last  = 1'b1;
          hist_we    = 1'b1;
          hist_wdata = next_byte_r;
          st_nxt     = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  lzd_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_r),
    .wdata (hist_wdata),
    .re    (hist_re),
    .raddr (raddr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      wp_r   <= '0;
      prod_r <= '0;
      fwd_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (in_fire && in_stream_start) begin
        wp_r   <= '0;
        prod_r <= '0;
      end else if (hist_we) begin
        wp_r <= wp_inc;
        if (prod_r < DEPTH_P) begin
          prod_r <= prod_r + 1'b1;
        end
      end
      if (hist_re) begin
        fwd_r <= hist_we && (raddr == wp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    next_byte_r <= next_byte_nxt;
    if (hist_re) begin
      rd_addr_r  <= raddr_inc;
      fwd_byte_r <= hist_wdata;
    end
  end

  // Output register: loads only when the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r   <= load_byte;
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_r;

  `LZD_ASSERT_NEXT(a_copy_exit, st_r == ST_COPY, (st_r == ST_COPY) || (st_r == ST_TAIL), "copy left without trailing byte")
  `LZD_ASSERT_ALWAYS(a_copy_cnt, (st_r != ST_COPY) || (cnt_r != '0), "copy active with zero count")
  `LZD_ASSERT_ALWAYS(a_write_emits, !hist_we || (out_load && (load_status == lzd_pkg::STS_DATA)), "history write without data result")
  `LZD_ASSERT_ALWAYS(a_prod_sat, prod_r <= DEPTH_P, "produced count above window size")

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the LZ77 token decompressor top level.
`timescale 1ns / 1ps

module testbench;

  localparam int HIST_DEPTH  = lzd_pkg::DEF_HISTORY_DEPTH;
  localparam int OFF_BYTES   = lzd_pkg::DEF_OFFSET_BYTES;
  localparam int LEN_BYTES   = lzd_pkg::DEF_LENGTH_BYTES;
  localparam int MAX_COPY    = lzd_pkg::DEF_MAX_COPY;
  // Settle well past the time that the longest copy occupies the block.
  localparam int SETTLE      = 100;
  localparam int QUIET_LIMIT = 4000;

  // Token parser state of the scoreboard's decoder.
  typedef enum logic [3:0] {
    HDR_OFFSET = 4'b0001,
    HDR_LENGTH = 4'b0010,
    LIT_RUN    = 4'b0100,
    COPY_NEXT  = 4'b1000
  } hdr_phase_t;

  typedef struct packed {
    logic [7:0]       data;
    lzd_pkg::status_t status;
    logic             last_run;
  } dec_result_t;

  logic             clk;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte         = 8'h00;
  logic             in_stream_start = 1'b0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [7:0]       out_byte;
  lzd_pkg::status_t out_status;
  logic             out_last_of_run;
  logic             cfg_we          = 1'b0;
  logic             cfg_wdata       = 1'b0;

  lz77_token_decompressor_top #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .OFFSET_BYTES (OFF_BYTES),
    .LENGTH_BYTES (LEN_BYTES),
    .MAX_COPY     (MAX_COPY)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_stream_start(in_stream_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder mirror: its own history window, pointers and parser, updated on
  // every accepted input transaction. Results go to decoded_q in output order.
  // ---------------------------------------------------------------------------
  logic [7:0]  hist [0:HIST_DEPTH-1];
  int unsigned wr_ptr     = 0;
  int unsigned produced   = 0;
  hdr_phase_t  phase      = HDR_OFFSET;
  int unsigned field_idx  = 0;
  logic [31:0] off_acc    = '0;
  logic [31:0] len_acc    = '0;
  int unsigned lit_left   = 0;
  bit          err_hold   = 1'b0;
  bit          pred_msb   = 1'b0;

  dec_result_t decoded_q[$];
  int          mismatch_count = 0;

  function automatic logic [31:0] merge_field(logic [31:0] acc, logic [7:0] b,
                                              int unsigned idx);
    if (pred_msb)
      return (acc << 8) | 32'(b);
    return acc | (32'(b) << (8 * (idx & 3)));
  endfunction

  function automatic void clear_parser();
    phase     = HDR_OFFSET;
    field_idx = 0;
    off_acc   = '0;
    len_acc   = '0;
    lit_left  = 0;
  endfunction

  // Every data byte lands in the window as well as on the output.
  function automatic void put_data(logic [7:0] b, logic last_run);
    dec_result_t r;
    hist[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (produced < HIST_DEPTH)
      produced++;
    r.data     = b;
    r.status   = lzd_pkg::STS_DATA;
    r.last_run = last_run;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void flag_error(lzd_pkg::status_t st);
    dec_result_t r;
    err_hold = 1'b1;
    clear_parser();
    r.data     = 8'h00;
    r.status   = st;
    r.last_run = 1'b1;
    decoded_q = {decoded_q, r};
  endfunction

  function automatic void decode_token_byte(logic [7:0] b, logic ss);
    int unsigned rd;
    if (ss) begin
      clear_parser();
      produced = 0;
      wr_ptr   = 0;
      err_hold = 1'b0;
    end
    if (err_hold)
      return;
    case (phase)
      HDR_OFFSET: begin
        off_acc = merge_field(off_acc, b, field_idx);
        field_idx++;
        if (field_idx >= OFF_BYTES) begin
          field_idx = 0;
          if (off_acc != 0 && off_acc > produced)
            flag_error(lzd_pkg::STS_BAD_OFFSET);
          else
            phase = HDR_LENGTH;
        end
      end
      HDR_LENGTH: begin
        len_acc = merge_field(len_acc, b, field_idx) & 32'h0000_FFFF;
        field_idx++;
        if (field_idx >= LEN_BYTES) begin
          field_idx = 0;
          if (off_acc == 0) begin
            lit_left = len_acc;
            if (lit_left != 0)
              phase = LIT_RUN;
            else
              clear_parser();  // empty literal run
          end else if (len_acc > MAX_COPY) begin
            flag_error(lzd_pkg::STS_BAD_LENGTH);
          end else begin
            phase = COPY_NEXT;
          end
        end
      end
      LIT_RUN: begin
        put_data(b, 1'b1);
        lit_left--;
        if (lit_left == 0)
          clear_parser();
      end
      COPY_NEXT: begin
        // Byte-by-byte replay, so an overlapping copy sees its own output.
        for (int unsigned i = 0; i < len_acc && i < MAX_COPY; i++) begin
          rd = (wr_ptr + HIST_DEPTH - (off_acc % (HIST_DEPTH + 1))) % HIST_DEPTH;
          put_data(hist[rd], 1'b0);
        end
        put_data(b, 1'b1);
        clear_parser();
      end
      default: clear_parser();
    endcase
  endfunction

  function automatic void check_result();
    dec_result_t want;
    if (decoded_q.size() == 0) begin
      mismatch_count++;
      $error("result with none expected: out_byte %0h out_status %0d", out_byte,
             out_status);
      return;
    end
    want = decoded_q.pop_front();
    if (out_byte !== want.data) begin
      mismatch_count++;
      $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
    end
    if (out_status !== want.status) begin
      mismatch_count++;
      $error("out_status: expected %0d, actual %0d", want.status, out_status);
    end
    if (out_last_of_run !== want.last_run) begin
      mismatch_count++;
      $error("out_last_of_run: expected %0b, actual %0b", want.last_run,
             out_last_of_run);
    end
  endfunction

  // Everything is sampled at the edge, before the DUT's updates land.
  // A result leaving at an edge never stems from the byte taken at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0)
        check_result();
      if (in_valid && in_stall === 1'b0)
        decode_token_byte(in_byte, in_stream_start);
      if (cfg_we)
        pred_msb = cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here.
  // ---------------------------------------------------------------------------
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_left    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < dst_idle_pct);
    end
  end

  // Watchdog: too long without any transaction on either channel.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transaction for %0d cycles, %0d results outstanding", QUIET_LIMIT,
           decoded_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stream generator. It tracks how much output the current stream has made so
  // that copy offsets stay in range unless an error is wanted.
  // ---------------------------------------------------------------------------
  bit          start_pending = 1'b0;
  bit          gen_msb       = 1'b0;
  int unsigned gen_produced  = 0;

  task automatic send_byte(input logic [7:0] b, input logic extra_ss);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_stream_start <= start_pending | extra_ss;
    start_pending = 1'b0;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
  endtask

  task automatic send_field(input logic [31:0] value, input int nbytes);
    int idx;
    for (int i = 0; i < nbytes; i++) begin
      idx = gen_msb ? nbytes - 1 - i : i;
      send_byte(value[8*idx +: 8], 1'b0);
    end
  endtask

  task automatic new_stream();
    start_pending = 1'b1;
    gen_produced  = 0;
  endtask

  task automatic gen_add(input int unsigned n);
    gen_produced = (gen_produced + n > HIST_DEPTH) ? HIST_DEPTH : gen_produced + n;
  endtask

  task automatic literal_token(input int unsigned len);
    send_field(32'd0, OFF_BYTES);
    send_field(len, LEN_BYTES);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom), 1'b0);
    gen_add(len);
  endtask

  task automatic copy_token(input int unsigned off, input int unsigned len,
                            input logic [7:0] nxt);
    send_field(off, OFF_BYTES);
    send_field(len, LEN_BYTES);
    send_byte(nxt, 1'b0);
    gen_add(len + 1);
  endtask

  // Wait until every expected result is out and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_msb(input bit v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_msb = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every token kind and each corner case.
  task automatic test_directed();
    set_msb(1'b0);
    new_stream();
    send_field(32'd0, OFF_BYTES);
    send_field(32'd3, LEN_BYTES);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    gen_add(3);
    literal_token(0);                  // empty literal run: nothing out
    copy_token(1, 0, 8'hA5);           // empty copy: only the trailing byte
    copy_token(2, MAX_COPY, 8'hFF);    // longest copy, overlapping its source
    send_field(32'd1, OFF_BYTES);      // copy length one past the limit
    send_field(MAX_COPY + 1, LEN_BYTES);
    send_byte(8'hFF, 1'b0);            // dropped while the error holds
    new_stream();
    send_field(32'd1, OFF_BYTES);      // any offset is too far in an empty stream
    drain();
  endtask

  // Fill the whole window, copy from its oldest byte, then reach just past it.
  task automatic test_window_limits();
    set_msb(1'b1);
    new_stream();
    literal_token(4);
    while (gen_produced < HIST_DEPTH)
      copy_token($urandom_range(gen_produced, 1), MAX_COPY, 8'($urandom));
    copy_token(HIST_DEPTH, MAX_COPY, 8'h3C);
    send_field(HIST_DEPTH + 1, OFF_BYTES);
    send_byte(8'h00, 1'b0);
    new_stream();
    send_field(32'hFFFF, OFF_BYTES);
    drain();
  endtask

  // Mostly well-formed tokens with random content; some errors, noise and
  // tokens cut short by a new stream.
  task automatic test_random_traffic(input int n_tokens, input bit msb);
    int          k;
    int unsigned len;
    int unsigned off;
    int unsigned lim;
    set_msb(msb);
    new_stream();
    for (int t = 0; t < n_tokens; t++) begin
      if (!start_pending && $urandom_range(39) == 0)
        new_stream();
      k = $urandom_range(99);
      if (k < 30 || (k < 85 && gen_produced == 0)) begin
        k = $urandom_range(9);
        if (k < 6)      len = $urandom_range(6, 1);
        else if (k < 8) len = 0;
        else            len = $urandom_range(64, 7);
        literal_token(len);
      end else if (k < 80) begin
        lim = (gen_produced < 8) ? gen_produced : 8;
        off = $urandom_range(1) ? $urandom_range(lim, 1) : $urandom_range(gen_produced, 1);
        k = $urandom_range(9);
        if (k < 4)      len = $urandom_range(4);
        else if (k < 8) len = $urandom_range(MAX_COPY - 1, 5);
        else            len = MAX_COPY;
        copy_token(off, len, 8'($urandom));
      end else if (k < 85) begin
        send_field($urandom_range(gen_produced, 1), OFF_BYTES);
        send_field($urandom_range(255, MAX_COPY + 1), LEN_BYTES);
        repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
        new_stream();
      end else if (k < 90) begin
        off = $urandom_range(1) ? gen_produced + 1 : $urandom_range(65535, gen_produced + 1);
        send_field(off, OFF_BYTES);
        repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
        new_stream();
      end else if (k < 95) begin
        repeat ($urandom_range(6, 1)) send_byte(8'($urandom), 1'($urandom_range(1)));
        new_stream();
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
        new_stream();
      end
    end
    drain();
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    new_stream();
    literal_token(8);
    hold_left = 300;
    repeat (4) copy_token($urandom_range(gen_produced, 1), MAX_COPY, 8'($urandom));
    literal_token(4);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 14;
    dst_idle_pct = 49;
    test_directed();
    test_random_traffic(6, 1'b0);

    src_idle_pct = 49;
    dst_idle_pct = 14;
    test_window_limits();
    test_random_traffic(6, 1'b1);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_traffic(6, 1'b0);
    test_backpressure();

    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
